>>> rtl/core/bilateral_normal_filter_top_macros.svh
// Assertion helpers for the concurrent checks in the top-level file.
`ifndef BILATERAL_NORMAL_FILTER_TOP_MACROS_SVH
`define BILATERAL_NORMAL_FILTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BNF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BNF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/bnf_pkg.sv
`timescale 1ns / 1ps
package bnf_pkg;

	// Stream payload widths.
	localparam int IN_DATA_W  = 176;
	localparam int OUT_DATA_W = 48;

	// Internal arithmetic widths.
	localparam int CD2_W  = 50;
	localparam int ND2_W  = 34;
	localparam int MUL_W  = 33;
	localparam int PROD_W = 66;
	localparam int ARG_W  = 68;

	// The exponent table covers arguments below 2^EXP_RANGE_LOG2 (Q32.32).
	localparam int EXP_RANGE_LOG2 = 4;
	localparam int ARG_LOG2       = EXP_RANGE_LOG2 + 32;
	localparam logic [63:0] EXP_NEG_ONE_Q32 = 64'd1580030169;
	localparam logic [63:0] NORM_MAX = 64'd16384;

	// Divider iterations and the last axis of a vector.
	localparam int DIV_STEPS = 64;
	localparam int BIT_W     = $clog2(DIV_STEPS);
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(DIV_STEPS - 1);
	localparam logic [1:0] LAST_AXIS = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CMUL, ST_CACC, ST_NMUL, ST_NACC,
		ST_GLO, ST_GHI, ST_GSUM, ST_GLOOK,
		ST_W1, ST_W2, ST_W3, ST_AMUL, ST_AACC,
		ST_DLOAD, ST_DSTEP, ST_DSTORE, ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE, MUL_CD, MUL_ND, MUL_GLO, MUL_GHI, MUL_W1, MUL_W2, MUL_AN
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_ACC_CD, OP_ACC_ND, OP_ARG_LO, OP_ARG_SUM, OP_GAUSS,
		OP_WEIGHT, OP_ACC_AN, OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_STORE, OP_FIN
	} dp_op_t;

	typedef struct packed {
		logic     ld;
		mul_sel_t mul;
		dp_op_t   op;
		logic [1:0] axis;
		logic     gsel;
	} dp_cmd_t;

	typedef struct packed {
		logic cmd;
		logic last;
		logic wt_zero;
	} dp_stat_t;

	// Division by a small literal step number of the series.
	function automatic logic [63:0] div_by_step(input logic [63:0] x, input int k);
		logic [63:0] r;
		unique case (k)
			1:  r = x;
			2:  r = x / 2;
			3:  r = x / 3;
			4:  r = x / 4;
			5:  r = x / 5;
			6:  r = x / 6;
			7:  r = x / 7;
			8:  r = x / 8;
			9:  r = x / 9;
			10: r = x / 10;
			11: r = x / 11;
			12: r = x / 12;
			13: r = x / 13;
			14: r = x / 14;
			15: r = x / 15;
			16: r = x / 16;
			17: r = x / 17;
			18: r = x / 18;
			19: r = x / 19;
			20: r = x / 20;
			default: r = x;
		endcase
		return r;
	endfunction

	// Table entry exp(-idx * range / depth) in Q1.frac, built at elaboration.
	function automatic logic [63:0] exp_entry(input int unsigned idx,
		input int unsigned lg_depth, input int unsigned frac);
		logic [63:0] num;
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] term;
		logic [63:0] sum;
		num = 64'(idx) << EXP_RANGE_LOG2;
		n = num >> lg_depth;
		f = ((num & ((64'd1 << lg_depth) - 64'd1)) << 32) >> lg_depth;
		term = 64'd1 << 32;
		sum = term;
		for (int k = 1; k <= 20; k++) begin
			term = div_by_step((term * f) >> 32, k);
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		for (int j = 0; j < 16; j++) begin
			if (64'(j) < n) begin
				sum = (sum * EXP_NEG_ONE_Q32 + (64'd1 << 31)) >> 32;
			end
		end
		return (sum + (64'd1 << (31 - frac))) >> (32 - frac);
	endfunction

endpackage

>>> rtl/core/bnf_ctrl.sv
`timescale 1ns / 1ps
module bnf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  bnf_pkg::dp_stat_t stat,
	output bnf_pkg::dp_cmd_t  cmd
);
	import bnf_pkg::*;

	state_t state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic gsel_q, gsel_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic out_valid_q;
	logic fin_go;

	// A finished result may be written once the output register is free or leaving.
	assign fin_go = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= '0;
			gsel_q <= 1'b0;
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q <= axis_d;
			gsel_q <= gsel_d;
			bit_q <= bit_d;
			if (cmd.op == OP_FIN) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		axis_d = axis_q;
		gsel_d = gsel_q;
		bit_d = bit_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && stat.cmd) begin
					state_d = ST_CMUL;
					axis_d = '0;
				end
			end
			ST_CMUL: state_d = ST_CACC;
			ST_CACC: begin
				if (axis_q == LAST_AXIS) begin
					state_d = ST_NMUL;
					axis_d = '0;
				end else begin
					state_d = ST_CMUL;
					axis_d = axis_q + 2'd1;
				end
			end
			ST_NMUL: state_d = ST_NACC;
			ST_NACC: begin
				if (axis_q == LAST_AXIS) begin
					state_d = ST_GLO;
					gsel_d = 1'b0;
				end else begin
					state_d = ST_NMUL;
					axis_d = axis_q + 2'd1;
				end
			end
			ST_GLO:  state_d = ST_GHI;
			ST_GHI:  state_d = ST_GSUM;
			ST_GSUM: state_d = ST_GLOOK;
			ST_GLOOK: begin
				if (gsel_q) begin
					state_d = ST_W1;
				end else begin
					state_d = ST_GLO;
					gsel_d = 1'b1;
				end
			end
			ST_W1: state_d = ST_W2;
			ST_W2: state_d = ST_W3;
			ST_W3: begin
				state_d = ST_AMUL;
				axis_d = '0;
			end
			ST_AMUL: state_d = ST_AACC;
			ST_AACC: begin
				priority if (axis_q != LAST_AXIS) begin
					state_d = ST_AMUL;
					axis_d = axis_q + 2'd1;
				end else if (!stat.last) begin
					state_d = ST_IDLE;
				end else if (stat.wt_zero) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_DLOAD;
					axis_d = '0;
				end
			end
			ST_DLOAD: begin
				state_d = ST_DSTEP;
				bit_d = '0;
			end
			ST_DSTEP: begin
				if (bit_q == LAST_BIT) begin
					state_d = ST_DSTORE;
				end else begin
					bit_d = bit_q + BIT_W'(1);
				end
			end
			ST_DSTORE: begin
				if (axis_q == LAST_AXIS) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_DLOAD;
					axis_d = axis_q + 2'd1;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		s_tready = 1'b0;
		cmd.ld = 1'b0;
		cmd.mul = MUL_NONE;
		cmd.op = OP_NONE;
		cmd.axis = axis_q;
		cmd.gsel = gsel_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.ld = s_tvalid;
			end
			ST_CMUL:   cmd.mul = MUL_CD;
			ST_CACC:   cmd.op = OP_ACC_CD;
			ST_NMUL:   cmd.mul = MUL_ND;
			ST_NACC:   cmd.op = OP_ACC_ND;
			ST_GLO:    cmd.mul = MUL_GLO;
			ST_GHI: begin
				cmd.mul = MUL_GHI;
				cmd.op = OP_ARG_LO;
			end
			ST_GSUM:   cmd.op = OP_ARG_SUM;
			ST_GLOOK:  cmd.op = OP_GAUSS;
			ST_W1:     cmd.mul = MUL_W1;
			ST_W2:     cmd.mul = MUL_W2;
			ST_W3:     cmd.op = OP_WEIGHT;
			ST_AMUL:   cmd.mul = MUL_AN;
			ST_AACC:   cmd.op = OP_ACC_AN;
			ST_DLOAD:  cmd.op = OP_DIV_LOAD;
			ST_DSTEP:  cmd.op = OP_DIV_STEP;
			ST_DSTORE: cmd.op = OP_DIV_STORE;
			ST_FIN:    cmd.op = fin_go ? OP_FIN : OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule

>>> rtl/core/bnf_dp.sv
`timescale 1ns / 1ps
module bnf_dp #(
	parameter int EXP_TABLE_DEPTH = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bnf_pkg::dp_cmd_t                cmd,
	output bnf_pkg::dp_stat_t               stat,
	input  logic [bnf_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	input  logic [31:0]                     spatial_scale,
	input  logic [31:0]                     normal_scale,
	output logic [bnf_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tuser
);
	import bnf_pkg::*;

	localparam int LG_DEPTH = $clog2(EXP_TABLE_DEPTH);
	localparam int EW = FRAC_BITS + 1;

	logic [EW-1:0] exp_tab [EXP_TABLE_DEPTH];

	// Centre facet and accumulators.
	logic signed [31:0] cc_q [3];
	logic signed [15:0] cn_q [3];
	logic signed [63:0] ws_q [3];
	logic [63:0] wt_q;

	// Current neighbour item and working registers.
	logic signed [31:0] ci_q [3];
	logic signed [15:0] ni_q [3];
	logic [31:0] area_q;
	logic last_q;
	logic [CD2_W-1:0] cd2_q;
	logic [ND2_W-1:0] nd2_q;
	logic [PROD_W-1:0] prod_q;
	logic [ARG_W-1:0] arg_q;
	logic [EW-1:0] gc_q, gn_q;
	logic [31:0] w_q;
	logic [63:0] rem_q, quo_q;
	logic sign_q;
	logic [15:0] res_q [3];
	logic [15:0] ox_q, oy_q, oz_q;
	logic zw_q;

	logic signed [32:0] dc;
	logic [31:0] mc;
	logic signed [16:0] dn;
	logic [16:0] mn;
	logic [16:0] nmag;
	logic [CD2_W-1:0] d2sel;
	logic [31:0] scale_sel;
	logic [MUL_W-1:0] mul_a, mul_b;
	logic d2big, over;
	logic [EW-1:0] gval;
	logic [31:0] w_new;
	logic [64:0] wt_sum;
	logic signed [48:0] an_add;
	logic signed [64:0] ws_sum;
	logic [63:0] ws_sat;
	logic [63:0] mag_sel;
	logic [64:0] div_shift;
	logic div_ge;
	logic [15:0] q_mag;

	// Constant exponent table, evaluated at elaboration.
	for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_tab
		assign exp_tab[gi] = EW'(exp_entry(gi, LG_DEPTH, FRAC_BITS));
	end

	// Per-axis differences and magnitudes.
	always_comb begin
		dc = 33'(cc_q[cmd.axis]) - 33'(ci_q[cmd.axis]);
		mc = dc[32] ? 32'(-dc) : dc[31:0];
		dn = 17'(cn_q[cmd.axis]) - 17'(ni_q[cmd.axis]);
		mn = dn[16] ? 17'(-dn) : 17'(dn);
		nmag = ni_q[cmd.axis][15] ? 17'(-17'(ni_q[cmd.axis])) : 17'(ni_q[cmd.axis]);
	end

	// Gaussian argument source.
	assign d2sel = cmd.gsel ? CD2_W'(nd2_q[ND2_W-1:12]) : cd2_q;
	assign scale_sel = cmd.gsel ? normal_scale : spatial_scale;
	assign d2big = |d2sel[CD2_W-1:ARG_LOG2];
	assign over = (scale_sel != 32'd0) && (d2big || (|arg_q[ARG_W-1:ARG_LOG2]));
	assign gval = over ? '0 : exp_tab[arg_q[ARG_LOG2-1 -: LG_DEPTH]];

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul)
			MUL_CD: begin
				mul_a = MUL_W'(mc);
				mul_b = MUL_W'(mc);
			end
			MUL_ND: begin
				mul_a = MUL_W'(mn);
				mul_b = MUL_W'(mn);
			end
			MUL_GLO: begin
				mul_a = MUL_W'(d2sel[17:0]);
				mul_b = MUL_W'(scale_sel);
			end
			MUL_GHI: begin
				mul_a = MUL_W'(d2sel[35:18]);
				mul_b = MUL_W'(scale_sel);
			end
			MUL_W1: begin
				mul_a = MUL_W'(area_q);
				mul_b = MUL_W'(gn_q);
			end
			MUL_W2: begin
				mul_a = prod_q[FRAC_BITS +: MUL_W];
				mul_b = MUL_W'(gc_q);
			end
			MUL_AN: begin
				mul_a = MUL_W'(w_q);
				mul_b = MUL_W'(nmag);
			end
			MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Weight and saturating accumulation.
	always_comb begin
		w_new = prod_q[FRAC_BITS + 1 +: 32];
		wt_sum = {1'b0, wt_q} + 65'(w_new);
		an_add = ni_q[cmd.axis][15] ? -$signed({1'b0, prod_q[47:0]})
			: $signed({1'b0, prod_q[47:0]});
		ws_sum = 65'(ws_q[cmd.axis]) + 65'(an_add);
		if (ws_sum[64] != ws_sum[63]) begin
			ws_sat = ws_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			ws_sat = ws_sum[63:0];
		end
	end

	// Restoring divider step and result clamp.
	always_comb begin
		mag_sel = ws_q[cmd.axis][63] ? 64'(-ws_q[cmd.axis]) : 64'(ws_q[cmd.axis]);
		div_shift = {rem_q, quo_q[63]};
		div_ge = div_shift >= {1'b0, wt_q};
		q_mag = (quo_q > NORM_MAX) ? NORM_MAX[15:0] : quo_q[15:0];
	end

	// Centre facet and accumulators, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				cc_q[k] <= '0;
				cn_q[k] <= '0;
				ws_q[k] <= '0;
			end
			wt_q <= '0;
		end else begin
			if (cmd.ld && !s_tuser) begin
				cc_q[0] <= s_tdata[31:0];
				cc_q[1] <= s_tdata[63:32];
				cc_q[2] <= s_tdata[95:64];
				cn_q[0] <= s_tdata[111:96];
				cn_q[1] <= s_tdata[127:112];
				cn_q[2] <= s_tdata[143:128];
			end
			if ((cmd.ld && !s_tuser) || cmd.op == OP_FIN) begin
				for (int k = 0; k < 3; k++) begin
					ws_q[k] <= '0;
				end
				wt_q <= '0;
			end else if (cmd.op == OP_WEIGHT) begin
				wt_q <= wt_sum[64] ? '1 : wt_sum[63:0];
			end else if (cmd.op == OP_ACC_AN) begin
				ws_q[cmd.axis] <= ws_sat;
			end
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.ld && s_tuser) begin
			ci_q[0] <= s_tdata[31:0];
			ci_q[1] <= s_tdata[63:32];
			ci_q[2] <= s_tdata[95:64];
			ni_q[0] <= s_tdata[111:96];
			ni_q[1] <= s_tdata[127:112];
			ni_q[2] <= s_tdata[143:128];
			area_q <= s_tdata[175:144];
			last_q <= s_tlast;
			cd2_q <= '0;
			nd2_q <= '0;
		end
		if (cmd.mul != MUL_NONE) begin
			prod_q <= PROD_W'(mul_a * mul_b);
		end
		unique case (cmd.op)
			OP_ACC_CD:  cd2_q <= cd2_q + CD2_W'(prod_q[63:16]);
			OP_ACC_ND:  nd2_q <= nd2_q + prod_q[ND2_W-1:0];
			OP_ARG_LO:  arg_q <= ARG_W'(prod_q);
			OP_ARG_SUM: arg_q <= arg_q + ARG_W'({prod_q, 18'd0});
			OP_GAUSS: begin
				if (cmd.gsel) begin
					gn_q <= gval;
				end else begin
					gc_q <= gval;
				end
			end
			OP_WEIGHT:  w_q <= w_new;
			OP_DIV_LOAD: begin
				rem_q <= '0;
				quo_q <= mag_sel;
				sign_q <= ws_q[cmd.axis][63];
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? 64'(div_shift - {1'b0, wt_q}) : div_shift[63:0];
				quo_q <= {quo_q[62:0], div_ge};
			end
			OP_DIV_STORE: res_q[cmd.axis] <= sign_q ? 16'(-q_mag) : q_mag;
			OP_FIN: begin
				if (wt_q == 64'd0) begin
					ox_q <= '0;
					oy_q <= '0;
					oz_q <= '0;
					zw_q <= 1'b1;
				end else begin
					ox_q <= res_q[0];
					oy_q <= res_q[1];
					oz_q <= res_q[2];
					zw_q <= 1'b0;
				end
			end
			OP_ACC_AN, OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign stat.cmd = s_tuser;
	assign stat.last = last_q;
	assign stat.wt_zero = (wt_q == 64'd0);
	assign m_tdata = {oz_q, oy_q, ox_q};
	assign m_tuser = zw_q;

endmodule

>>> rtl/core/bilateral_normal_filter_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Signals                        Content
// s_       in         tvalid tready tdata tuser tlast one facet: centre or neighbour
// m_       out        tvalid tready tdata tuser       filtered normal per group
// apb      in/out     psel penable pwrite paddr ...   two scale registers
//
// A centre item is taken and stored while the block stays idle; a neighbour item passes
// through the shared 33x33 multiplier, and the last neighbour of a group with a non-zero
// weight sum then runs the bit-serial divider for each axis before the output register
// is written.
// Reset clears the centre facet, the accumulators and the handshake state.
// A waiting result does not block the next group until that group finishes.
module bilateral_normal_filter_top #(
	parameter int EXP_TABLE_DEPTH = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cent_x, cent_y, cent_z, norm_x, norm_y, norm_z, double_area
	input  logic [175:0] s_tdata,
	// cmd
	input  logic [0:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_x, out_y, out_z
	output logic [47:0] m_tdata,
	// zero_weight
	output logic [0:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bnf_pkg::*;

	`include "bilateral_normal_filter_top_macros.svh"

	localparam logic REG_SPATIAL = 1'b0;

	logic [31:0] spatial_q, normal_q;
	dp_cmd_t cmd;
	dp_stat_t stat;

	// Register file: a write transaction completes in the access cycle.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spatial_q <= 32'd65536;
			normal_q <= 32'd819200;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_SPATIAL) begin
				spatial_q <= pwdata;
			end else begin
				normal_q <= pwdata;
			end
		end
	end
	assign prdata = (paddr[2] == REG_SPATIAL) ? spatial_q : normal_q;

	bnf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat(stat),
		.cmd(cmd)
	);

	bnf_dp #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser[0]),
		.s_tlast(s_tlast),
		.spatial_scale(spatial_q),
		.normal_scale(normal_q),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser[0])
	);

	// No result is written over one that has not been taken.
	`BNF_ASSERT_SAME(a_no_overwrite, cmd.op == OP_FIN, !m_tvalid || m_tready, "result overwritten")
	// The datapath never works while an input transaction can be taken.
	`BNF_ASSERT_SAME(a_busy_stall, cmd.op != OP_NONE, !s_tready, "input taken while busy")
	// A centre item leaves the block ready again in the next cycle.
	`BNF_ASSERT_NEXT(a_centre_one_cycle, s_tvalid && s_tready && !s_tuser[0], s_tready,
		"centre item not finished in one cycle")

endmodule

>>> test/bilateral_normal_filter_top_tb.sv
`timescale 1ns / 1ps
module bilateral_normal_filter_top_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;
	localparam int TAB_DEPTH = 256;
	localparam logic [2:0] ADDR_SPATIAL = 3'd0;
	localparam logic [2:0] ADDR_NORMAL = 3'd4;
	localparam logic CMD_CENTRE = 1'b0;
	localparam logic CMD_NEIGHBOUR = 1'b1;

	typedef struct packed {
		logic cmd;
		logic signed [31:0] cx, cy, cz;
		logic signed [15:0] nx, ny, nz;
		logic [31:0] area;
		logic last;
	} facet_t;

	localparam int FACET_W = $bits(facet_t);

	typedef struct packed {
		logic signed [15:0] x, y, z;
		logic zw;
	} normal_t;

	typedef struct {
		facet_t f;
		bit typed;
		normal_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [175:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bilateral_normal_filter_top i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	longint unsigned exp_lut[TAB_DEPTH];
	logic [31:0] spatial_scale_q, normal_scale_q;
	logic signed [31:0] centre_c[3];
	logic signed [15:0] centre_n[3];
	logic signed [63:0] normal_acc[3];
	logic [63:0] weight_acc;

	normal_t pending_normals[$];
	int errors = 0;
	bit calm = 1'b0;
	int unsigned quiet_cycles = 0;

	// Exponent table entry exp(-i/16) in Q1.16, built in Q32 arithmetic.
	function automatic longint unsigned exp_value(int unsigned i);
		longint unsigned num, n, f, term, sum;
		num = longint'(i) * 16;
		n = num / TAB_DEPTH;
		f = ((num % TAB_DEPTH) << 32) / TAB_DEPTH;
		term = 64'd1 << 32;
		sum = term;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * f) >> 32) / k;
			if (k % 2) sum -= term; else sum += term;
		end
		for (longint unsigned j = 0; j < n; j++)
			sum = (sum * 64'd1580030169 + (64'd1 << 31)) >> 32;
		return (sum + (64'd1 << 15)) >> 16;
	endfunction

	function automatic longint unsigned gauss_of(longint unsigned d2, logic [31:0] scale);
		if (scale == 0) return exp_lut[0];
		if (d2 > ((64'd1 << 36) - 1) / scale) return 0;
		return exp_lut[(d2 * scale) >> 28];
	endfunction

	// Applies one facet to the predictor; returns 1 when a filtered normal is due.
	function automatic bit filter_facet(facet_t f, output normal_t r);
		logic signed [31:0] c[3];
		logic signed [15:0] n[3];
		longint dc, dn;
		longint unsigned mc, mn, cd2, nd2, wc, ws, w, mag, q;
		logic signed [63:0] add, s;
		logic signed [64:0] t;
		logic [64:0] wt;
		logic [63:0] v[3];
		c = '{f.cx, f.cy, f.cz};
		n = '{f.nx, f.ny, f.nz};
		r = '0;
		if (f.cmd == CMD_CENTRE) begin
			centre_c = c;
			centre_n = n;
			normal_acc = '{default: '0};
			weight_acc = '0;
			return 0;
		end
		cd2 = 0;
		nd2 = 0;
		for (int k = 0; k < 3; k++) begin
			dc = longint'(centre_c[k]) - longint'(c[k]);
			dn = longint'(centre_n[k]) - longint'(n[k]);
			mc = dc < 0 ? -dc : dc;
			mn = dn < 0 ? -dn : dn;
			cd2 += (mc * mc) >> 16;
			nd2 += mn * mn;
		end
		nd2 >>= 12;
		wc = gauss_of(cd2, spatial_scale_q);
		ws = gauss_of(nd2, normal_scale_q);
		w = (((longint'(f.area) * ws) >> 16) * wc) >> 17;
		// Saturating accumulation.
		for (int k = 0; k < 3; k++) begin
			add = longint'(w) * longint'(n[k]);
			t = $signed({normal_acc[k][63], normal_acc[k]}) + $signed({add[63], add});
			if (t[64] != t[63])
				normal_acc[k] = t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			else
				normal_acc[k] = t[63:0];
		end
		wt = {1'b0, weight_acc} + w;
		weight_acc = wt[64] ? '1 : wt[63:0];
		if (!f.last) return 0;
		if (weight_acc == 0) begin
			r.zw = 1'b1;
		end else begin
			for (int k = 0; k < 3; k++) begin
				s = normal_acc[k];
				mag = s[63] ? 64'd0 - s : s;
				q = mag / weight_acc;
				if (q > 16384) q = 16384;
				v[k] = s[63] ? 64'd0 - q : q;
			end
			r.x = v[0][15:0];
			r.y = v[1][15:0];
			r.z = v[2][15:0];
		end
		normal_acc = '{default: '0};
		weight_acc = '0;
		return 1;
	endfunction

	function automatic bit idle_roll();
		return !calm && ($urandom_range(99) < 34);
	endfunction

	// Receiving side: random back-pressure and comparison against the oldest expectation.
	always @(posedge clk) begin
		normal_t want;
		if (m_tvalid && m_tready) begin
			if (pending_normals.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				want = pending_normals.pop_front();
				if (m_tdata[15:0] !== want.x) begin
					$error("out_x expected %0d actual %0d", want.x, $signed(m_tdata[15:0]));
					errors++;
				end
				if (m_tdata[31:16] !== want.y) begin
					$error("out_y expected %0d actual %0d", want.y, $signed(m_tdata[31:16]));
					errors++;
				end
				if (m_tdata[47:32] !== want.z) begin
					$error("out_z expected %0d actual %0d", want.z, $signed(m_tdata[47:32]));
					errors++;
				end
				if (m_tuser[0] !== want.zw) begin
					$error("zero_weight expected %0d actual %0d", want.zw, m_tuser[0]);
					errors++;
				end
			end
		end
		m_tready <= arst_n && !idle_roll();
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("bilateral_normal_filter_top: mismatch");
			$finish;
		end
	end

	task automatic send_facet(input facet_t f, input bit typed = 0, input normal_t e = '0);
		normal_t r;
		while (idle_roll()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {f.area, f.nz, f.ny, f.nx, f.cz, f.cy, f.cx};
		s_tuser <= f.cmd;
		s_tlast <= f.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (filter_facet(f, r))
			pending_normals.insert(pending_normals.size(), typed ? e : r);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_SPATIAL) spatial_scale_q = value;
		else normal_scale_q = value;
	endtask

	// Waits for every result, then lets the block finish any trailing neighbour.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic facet_t fac(logic cmd, int cx, int cy, int cz,
		int nx, int ny, int nz, longint area, int last);
		return '{cmd, cx, cy, cz, 16'(nx), 16'(ny), 16'(nz), 32'(area), last[0]};
	endfunction

	function automatic logic [15:0] clamp_norm(int v);
		if (v > 16384) return 16'sd16384;
		if (v < -16384) return -16'sd16384;
		return v[15:0];
	endfunction

	function automatic facet_t noise_facet();
		facet_t f;
		f = FACET_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		return f;
	endfunction

	// One well-formed group: a centre and neighbours close to it in space and normal.
	task automatic random_group(input int span_c, input int span_n);
		facet_t ctr, nb;
		int count;
		ctr = noise_facet();
		ctr.cmd = CMD_CENTRE;
		ctr.nx = 16'($urandom_range(32768) - 16384);
		ctr.ny = 16'($urandom_range(32768) - 16384);
		ctr.nz = 16'($urandom_range(32768) - 16384);
		send_facet(ctr);
		count = $urandom_range(1, 6);
		for (int i = 0; i < count; i++) begin
			nb = noise_facet();
			nb.cmd = CMD_NEIGHBOUR;
			nb.cx = ctr.cx + $signed($urandom_range(2 * span_c) - span_c);
			nb.cy = ctr.cy + $signed($urandom_range(2 * span_c) - span_c);
			nb.cz = ctr.cz + $signed($urandom_range(2 * span_c) - span_c);
			nb.nx = clamp_norm(int'(ctr.nx) + int'($urandom_range(2 * span_n)) - span_n);
			nb.ny = clamp_norm(int'(ctr.ny) + int'($urandom_range(2 * span_n)) - span_n);
			nb.nz = clamp_norm(int'(ctr.nz) + int'($urandom_range(2 * span_n)) - span_n);
			if ($urandom_range(9) == 0) nb.area = $urandom_range(65535);
			nb.last = (i == count - 1);
			send_facet(nb);
		end
	endtask

	task automatic random_phase(input int items);
		int sent;
		facet_t f;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9) < 8) begin
				random_group(1 << $urandom_range(10, 18), $urandom_range(200, 12000));
				sent += 4;
			end else begin
				f = noise_facet();
				send_facet(f);
				sent++;
			end
		end
		// Close any open group so that its result is flushed.
		f = noise_facet();
		f.cmd = CMD_NEIGHBOUR;
		f.last = 1'b1;
		send_facet(f);
		drain();
	endtask

	initial begin
		row_t rows[$];
		normal_t z1;
		for (int i = 0; i < TAB_DEPTH; i++) exp_lut[i] = exp_value(i);
		spatial_scale_q = 32'd65536;
		normal_scale_q = 32'd819200;
		centre_c = '{default: '0};
		centre_n = '{default: '0};
		normal_acc = '{default: '0};
		weight_acc = '0;
		z1 = '{16'sd0, 16'sd0, 16'sd0, 1'b1};

		// Directed rows; typed expectations where they follow at a glance.
		rows.insert(rows.size(),
			'{fac(CMD_NEIGHBOUR, 0, 0, 0, 0, 0, 16384, 131072, 1), 1, z1});
		rows.insert(rows.size(), '{fac(CMD_CENTRE, 0, 0, 0, 16384, 0, 0, 0, 0), 0, '0});
		rows.insert(rows.size(), '{fac(CMD_NEIGHBOUR, 0, 0, 0, 16384, 0, 0, 65536, 1), 1,
			'{16'sd16384, 16'sd0, 16'sd0, 1'b0}});
		rows.insert(rows.size(), '{fac(CMD_CENTRE, 32'h7FFFFFFF, 32'h80000000, 0,
			-16384, -16384, -16384, 0, 0), 0, '0});
		rows.insert(rows.size(), '{fac(CMD_NEIGHBOUR, 32'h7FFFFFFF, 32'h80000000, 0,
			-16384, -16384, -16384, 32'hFFFFFFFF, 1), 1,
			'{-16'sd16384, -16'sd16384, -16'sd16384, 1'b0}});
		rows.insert(rows.size(),
			'{fac(CMD_CENTRE, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 0, 0), 0, '0});
		rows.insert(rows.size(),
			'{fac(CMD_NEIGHBOUR, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 65536, 1), 1,
			'{16'sd16384, -16'sd16384, 16'sd0, 1'b0}});
		rows.insert(rows.size(),
			'{fac(CMD_NEIGHBOUR, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 0, 1), 1, z1});
		rows.insert(rows.size(),
			'{fac(CMD_CENTRE, 0, 0, 0, 1000, -2000, 16000, 32'hFFFFFFFF, 1), 0, '0});
		rows.insert(rows.size(), '{fac(CMD_NEIGHBOUR, 30000, -20000, 5000, 1200, -2100, 15900,
			98304, 0), 0, '0});
		rows.insert(rows.size(), '{fac(CMD_NEIGHBOUR, -65536, 4000, 0, 900, -1800, 16100,
			32'hFFFFFFFF, 0), 0, '0});
		rows.insert(rows.size(),
			'{fac(CMD_NEIGHBOUR, 1, 1, 1, 3000, -3000, 14000, 1, 0), 0, '0});
		rows.insert(rows.size(), '{fac(CMD_NEIGHBOUR, 70000, 70000, -70000, 1000, -2000, 16000,
			200000, 1), 0, '0});
		rows.insert(rows.size(), '{fac(CMD_NEIGHBOUR, 32'h80000000, 32'h80000000, 32'h80000000,
			1000, -2000, 16000, 65536, 1), 1, z1});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_facet(rows[i].f, rows[i].typed, rows[i].e);
		drain();

		// Zero scales: every Gaussian is the first table entry.
		write_reg(ADDR_SPATIAL, 32'd0);
		write_reg(ADDR_NORMAL, 32'd0);
		foreach (rows[i]) send_facet(rows[i].f);
		random_phase(60);

		// Largest scales: only very close matches keep any weight.
		write_reg(ADDR_SPATIAL, 32'hFFFFFFFF);
		write_reg(ADDR_NORMAL, 32'hFFFFFFFF);
		random_phase(40);

		// Defaults with no idling on either side.
		write_reg(ADDR_SPATIAL, 32'd65536);
		write_reg(ADDR_NORMAL, 32'd819200);
		calm = 1'b1;
		random_phase(80);
		calm = 1'b0;

		random_phase(80);

		for (int p = 0; p < 3; p++) begin
			write_reg(ADDR_SPATIAL, $urandom_range(1, 32'h40000));
			write_reg(ADDR_NORMAL, $urandom);
			random_phase(50);
		end

		if (errors == 0) begin
			$display("bilateral_normal_filter_top: match");
		end else begin
			$display("bilateral_normal_filter_top: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bnf_pkg.sv
rtl/core/bnf_ctrl.sv
rtl/core/bnf_dp.sv
rtl/core/bilateral_normal_filter_top.sv
test/bilateral_normal_filter_top_tb.sv
